// ----- rtl/core/xcfp_pkg.sv -----
// Shared constants and types for the xor-checked frame parser.
package xcfp_pkg;

  // Largest payload a frame may carry.
  localparam int MAX_PAYLOAD = 32;

  // Internal widths follow MAX_PAYLOAD.
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // Fixed widths of the fields on the ports.
  localparam int BYTE_W           = 8;
  localparam int PAYLOAD_LENGTH_W = 6;
  localparam int BYTE_INDEX_W     = 5;
  localparam int CFG_INDEX_W      = 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL   = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;
  localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'h55;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_cmd;    // capture command byte, seed checksum
    logic xor_len;     // fold length byte into checksum
    logic load_len;    // capture payload length
    logic clr_idx;     // reset the byte counter
    logic write_byte;  // store payload byte, fold it, advance counter
    logic inc_idx;     // advance the read counter
    logic emit_load;   // load the output register with one result
  } xcfp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hdr_match;
    logic tail_match;
    logic len_over;
    logic len_zero;
    logic len_in_zero;
    logic fill_done;
    logic xor_match;
    logic out_free;
    logic emit_last;
  } xcfp_status_t;

endpackage

// ----- rtl/core/xcfp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module xcfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/xcfp_dp.sv -----
// Datapath of the frame parser: frame registers, checksum, payload RAM, output register.
module xcfp_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  xcfp_pkg::xcfp_cmd_t                    cmd,
  output xcfp_pkg::xcfp_status_t                 status,
  input  logic                                   cfg_we,
  input  logic [xcfp_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [xcfp_pkg::BYTE_W-1:0]            cfg_data,
  input  logic [xcfp_pkg::BYTE_W-1:0]            rx_byte,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic [xcfp_pkg::BYTE_W-1:0]            command,
  output logic [xcfp_pkg::PAYLOAD_LENGTH_W-1:0]  payload_length,
  output logic [xcfp_pkg::BYTE_INDEX_W-1:0]      byte_index,
  output logic [xcfp_pkg::BYTE_W-1:0]            payload_byte,
  output logic                                   has_byte,
  output logic                                   last
);

  logic [xcfp_pkg::BYTE_W-1:0] header_value;
  logic [xcfp_pkg::BYTE_W-1:0] tail_value;
  logic [xcfp_pkg::BYTE_W-1:0] frame_command;
  logic [xcfp_pkg::LEN_W-1:0]  frame_length;
  logic [xcfp_pkg::LEN_W-1:0]  idx;
  logic [xcfp_pkg::BYTE_W-1:0] running_xor;
  logic [xcfp_pkg::BYTE_W-1:0] ram_q;
  logic [xcfp_pkg::LEN_W-1:0]  idx_plus1;

  assign idx_plus1 = idx + xcfp_pkg::LEN_W'(1);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= xcfp_pkg::HEADER_RESET;
      tail_value   <= xcfp_pkg::TAIL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        xcfp_pkg::REG_HEADER: header_value <= cfg_data;
        xcfp_pkg::REG_TAIL:   tail_value   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame registers and checksum.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_command <= '0;
      frame_length  <= '0;
      idx           <= '0;
      running_xor   <= '0;
    end else begin
      if (cmd.load_cmd) begin
        frame_command <= rx_byte;
        running_xor   <= rx_byte;
      end
      if (cmd.xor_len || cmd.write_byte) begin
        running_xor <= running_xor ^ rx_byte;
      end
      if (cmd.load_len) begin
        frame_length <= xcfp_pkg::LEN_W'(rx_byte);
      end
      if (cmd.clr_idx) begin
        idx <= '0;
      end else if (cmd.write_byte || cmd.inc_idx) begin
        idx <= idx_plus1;
      end
    end
  end

  xcfp_ram #(
    .WIDTH (xcfp_pkg::BYTE_W),
    .DEPTH (xcfp_pkg::MAX_PAYLOAD)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.write_byte),
    .wr_addr (idx[xcfp_pkg::IDX_W-1:0]),
    .wr_data (rx_byte),
    .rd_addr (idx[xcfp_pkg::IDX_W-1:0]),
    .rd_data (ram_q)
  );

  // Output register: hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      command        <= frame_command;
      payload_length <= xcfp_pkg::PAYLOAD_LENGTH_W'(frame_length);
      byte_index     <= xcfp_pkg::BYTE_INDEX_W'(idx);
      payload_byte   <= status.len_zero ? '0 : ram_q;
      has_byte       <= !status.len_zero;
      last           <= status.emit_last;
    end
  end

  always_comb begin
    status.hdr_match   = (rx_byte == header_value);
    status.tail_match  = (rx_byte == tail_value);
    status.len_over    = (rx_byte > xcfp_pkg::BYTE_W'(xcfp_pkg::MAX_PAYLOAD));
    status.len_zero    = (frame_length == '0);
    status.len_in_zero = (rx_byte == '0);
    status.fill_done   = (idx_plus1 >= frame_length);
    status.xor_match   = (running_xor == rx_byte);
    status.out_free    = !out_valid || !out_stall;
    status.emit_last   = (frame_length == '0) || (idx_plus1 == frame_length);
  end

endmodule

// ----- rtl/core/xcfp_ctrl.sv -----
// Controller of the frame parser: frame phase sequencing and result emission.
module xcfp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  xcfp_pkg::xcfp_status_t status,
  output xcfp_pkg::xcfp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_HEADER,
    S_COMMAND,
    S_LENGTH,
    S_PAYLOAD,
    S_CHECK,
    S_TAIL,
    S_READ,
    S_LOAD
  } state_t;

  state_t state;
  state_t state_next;
  logic   acc;

  assign in_stall = (state == S_READ) || (state == S_LOAD);
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HEADER;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_HEADER: begin
        if (acc && status.hdr_match) state_next = S_COMMAND;
      end
      S_COMMAND: begin
        if (acc) begin
          cmd.load_cmd = 1'b1;
          state_next   = S_LENGTH;
        end
      end
      S_LENGTH: begin
        if (acc) begin
          cmd.xor_len = 1'b1;
          if (status.len_over) begin
            state_next = S_HEADER;
          end else begin
            cmd.load_len = 1'b1;
            cmd.clr_idx  = 1'b1;
            // length byte is still on rx_byte: decide zero length from it
            state_next   = status.len_in_zero ? S_CHECK : S_PAYLOAD;
          end
        end
      end
      S_PAYLOAD: begin
        if (acc) begin
          cmd.write_byte = 1'b1;
          if (status.fill_done) state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (acc) state_next = status.xor_match ? S_TAIL : S_HEADER;
      end
      S_TAIL: begin
        if (acc) begin
          if (status.tail_match) begin
            cmd.clr_idx = 1'b1;
            state_next  = S_READ;
          end else begin
            state_next = S_HEADER;
          end
        end
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.emit_last) begin
            state_next = S_HEADER;
          end else begin
            cmd.inc_idx = 1'b1;
            state_next  = S_READ;
          end
        end
      end
      default: state_next = S_HEADER;
    endcase
  end

endmodule

// ----- rtl/core/xor_checked_frame_parser.sv -----
// Top level of the xor-checked frame parser.
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) carries one received byte per
//   item. Frames are header, command, length, payload, checksum, tail; the
//   checksum is the XOR of command, length and all payload bytes.
//   Output channel (out_valid / out_stall / result fields) carries one item per
//   payload byte of a good frame, or one empty item for a zero-length payload;
//   the final item of a frame has last set.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) sets the header
//   byte (index 0) and the tail byte (index 1); cfg_ready is always high.
// Timing:
//   While parsing, one byte is accepted every cycle. After a good tail, in_stall
//   is high while results are read from the payload RAM: each result takes a
//   RAM read through the registered read port, then an output load that waits
//   while a stalled result holds the output register; input resumes the cycle
//   after the last result is loaded into the output register.
// Reset (rst, synchronous): parser waits for a header, header/tail bytes return
//   to 0xAA/0x55, the output register empties. Payload RAM is not cleared.
// Stall: a stalled result holds in the output register and the emission loop
//   waits, so input stays stalled until every result of the frame is loaded.
module xor_checked_frame_parser (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [xcfp_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [xcfp_pkg::BYTE_W-1:0]            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [xcfp_pkg::BYTE_W-1:0]            rx_byte,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [xcfp_pkg::BYTE_W-1:0]            command,
  output logic [xcfp_pkg::PAYLOAD_LENGTH_W-1:0]  payload_length,
  output logic [xcfp_pkg::BYTE_INDEX_W-1:0]      byte_index,
  output logic [xcfp_pkg::BYTE_W-1:0]            payload_byte,
  output logic                                   has_byte,
  output logic                                   last
);

  xcfp_pkg::xcfp_cmd_t    dp_cmd;
  xcfp_pkg::xcfp_status_t dp_status;

  // Registers may be written at any time the block is idle.
  assign cfg_ready = 1'b1;

  xcfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  xcfp_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (dp_cmd),
    .status         (dp_status),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .rx_byte        (rx_byte),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .command        (command),
    .payload_length (payload_length),
    .byte_index     (byte_index),
    .payload_byte   (payload_byte),
    .has_byte       (has_byte),
    .last           (last)
  );

  // Results are only loaded while input is held off.
  a_emit_stalls_input: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.emit_load |-> in_stall)
    else $error("result loaded while input accepted");

  // More results pending: input must stay held.
  a_pending_holds_input: assert property (@(posedge clk) disable iff (rst)
    (dp_cmd.emit_load && !dp_status.emit_last) |=> in_stall)
    else $error("input released before frame fully emitted");

  // Emission starts only after a matching tail byte was accepted.
  a_emit_after_tail: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && dp_status.tail_match))
    else $error("emission started without a good tail");

  // A new result appears only when one was loaded.
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(dp_cmd.emit_load))
    else $error("output valid without a load");

endmodule
